// ===== rtl/core/bsr_pkg.sv =====
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared constants, controller state type and control/status bundles for the
// bisection square root block.
// ----------------------------------------------------------------------------
package bsr_pkg;

   localparam int DATA_W         = 32;
   localparam int ITER_W         = 6;
   localparam int FRAC_BITS      = 16;
   localparam int MAX_ITERATIONS = 48;
   localparam int CNT_W          = $clog2(MAX_ITERATIONS + 1);
   localparam int SQ_W           = DATA_W + FRAC_BITS;
   localparam int PROD_W         = 2 * DATA_W;

   localparam logic [DATA_W-1:0] ONE_FIXED = DATA_W'(64'd1 << FRAC_BITS);
   localparam logic [DATA_W-1:0] TOL_RESET = DATA_W'(6554);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_CMP,
      ST_FIN
   } bsr_state_type;

   // controller -> datapath
   typedef struct packed {
      logic start;    // load a new operand
      logic square;   // register mid * mid
      logic advance;  // halve the interval
      logic settle;   // record the converged flag
      logic emit;     // load the output register
   } bsr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic special;  // operand is zero or exactly one
      logic in_band;  // square is inside the tolerance band
      logic at_cap;   // iteration cap reached
      logic out_free; // output register can take a result
   } bsr_stat_type;

endpackage

// ===== rtl/core/bsr_req_if.sv =====
// ----------------------------------------------------------------------------
// bsr_req_if
// Operand channel: valid/ready handshake carrying one Q16.16 value.
// ----------------------------------------------------------------------------
interface bsr_req_if;
   logic                       valid;
   logic                       ready;
   logic [bsr_pkg::DATA_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/core/bsr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bsr_rsp_if
// Result channel: valid/ready handshake carrying root, iteration count and
// converged flag.
// ----------------------------------------------------------------------------
interface bsr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bsr_pkg::DATA_W-1:0] root;
   logic [bsr_pkg::ITER_W-1:0] iterations;
   logic                       converged;

   modport source (output valid, output root, output iterations, output converged,
                   input ready);
   modport sink   (input valid, input root, input iterations, input converged,
                   output ready);
endinterface

// ===== rtl/core/bsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsr_ctrl
// Sequencer for the bisection loop: accept, square, compare/halve, deliver.
// ----------------------------------------------------------------------------
module bsr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bsr_pkg::bsr_stat_type stat,
   output bsr_pkg::bsr_cmd_type  cmd
);

   bsr_pkg::bsr_state_type state_ff;
   bsr_pkg::bsr_state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsr_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = stat.special ? bsr_pkg::ST_FIN : bsr_pkg::ST_MUL;
            end
         end
         bsr_pkg::ST_MUL: begin
            state_in = bsr_pkg::ST_CMP;
         end
         bsr_pkg::ST_CMP: begin
            state_in = (stat.in_band || stat.at_cap) ? bsr_pkg::ST_FIN : bsr_pkg::ST_MUL;
         end
         bsr_pkg::ST_FIN: begin
            if (stat.out_free) begin
               state_in = bsr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bsr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      case (state_ff)
         bsr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         bsr_pkg::ST_MUL: begin
            cmd.square = 1'b1;
         end
         bsr_pkg::ST_CMP: begin
            cmd.settle  = 1'b1;
            cmd.advance = !stat.in_band && !stat.at_cap;
         end
         bsr_pkg::ST_FIN: begin
            cmd.emit = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/bsr_dpath.sv =====
// ----------------------------------------------------------------------------
// bsr_dpath
// Interval registers, squaring multiplier, tolerance band compare, tolerance
// register and result output register.
// ----------------------------------------------------------------------------
module bsr_dpath (
   input  logic                       clock,
   input  logic                       reset,
   input  bsr_pkg::bsr_cmd_type       cmd,
   output bsr_pkg::bsr_stat_type      stat,
   input  logic                       csr_wr_en,
   input  logic [bsr_pkg::DATA_W-1:0] csr_wr_data,
   input  logic [bsr_pkg::DATA_W-1:0] req_value,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [bsr_pkg::DATA_W-1:0] rsp_root,
   output logic [bsr_pkg::ITER_W-1:0] rsp_iterations,
   output logic                       rsp_converged
);

   logic [bsr_pkg::DATA_W-1:0] tol_ff;
   logic [bsr_pkg::DATA_W-1:0] lo_ff,  lo_in;
   logic [bsr_pkg::DATA_W-1:0] hi_ff,  hi_in;
   logic [bsr_pkg::DATA_W-1:0] mid_ff, mid_in;
   logic [bsr_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                       conv_ff, conv_in;
   logic [bsr_pkg::SQ_W-1:0]   target_ff, target_in;
   logic [bsr_pkg::SQ_W-1:0]   lower_ff, lower_in;
   logic [bsr_pkg::SQ_W:0]     upper_ff, upper_in;
   logic [bsr_pkg::PROD_W-1:0] prod_ff;

   logic                       rsp_valid_ff;
   logic [bsr_pkg::DATA_W-1:0] root_ff;
   logic [bsr_pkg::ITER_W-1:0] iter_ff;
   logic                       conv_out_ff;

   logic                       is_zero, is_one;
   logic [bsr_pkg::DATA_W-1:0] hi_init;
   logic [bsr_pkg::SQ_W-1:0]   tol_wide;
   logic                       below, in_band;
   logic [bsr_pkg::DATA_W:0]   sum_up, sum_dn;
   logic [63:0]                count_wide;

   assign is_zero = (req_value == '0);
   assign is_one  = (req_value == bsr_pkg::ONE_FIXED);
   assign hi_init = (req_value > bsr_pkg::ONE_FIXED) ? req_value : bsr_pkg::ONE_FIXED;
   assign tol_wide = bsr_pkg::SQ_W'(tol_ff) << bsr_pkg::FRAC_BITS;

   // |sq - target| <= tol  <=>  target - tol <= sq <= target + tol
   assign below   = prod_ff < bsr_pkg::PROD_W'(target_ff);
   assign in_band = (prod_ff >= bsr_pkg::PROD_W'(lower_ff)) &&
                    (prod_ff <= bsr_pkg::PROD_W'(upper_ff));

   // both candidate midpoints in parallel with the compare
   assign sum_up = {1'b0, mid_ff} + {1'b0, hi_ff};
   assign sum_dn = {1'b0, lo_ff}  + {1'b0, mid_ff};

   assign count_wide = 64'(count_ff);

   always_comb begin
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      count_in  = count_ff;
      conv_in   = conv_ff;
      target_in = target_ff;
      lower_in  = lower_ff;
      upper_in  = upper_ff;
      if (cmd.start) begin
         target_in = bsr_pkg::SQ_W'(req_value) << bsr_pkg::FRAC_BITS;
         upper_in  = (bsr_pkg::SQ_W+1)'(target_in) + (bsr_pkg::SQ_W+1)'(tol_wide);
         lower_in  = (target_in >= tol_wide) ? (target_in - tol_wide) : '0;
         lo_in     = '0;
         hi_in     = hi_init;
         count_in  = '0;
         conv_in   = 1'b1;
         if (is_zero) begin
            mid_in = '0;
         end else if (is_one) begin
            mid_in = bsr_pkg::ONE_FIXED;
         end else begin
            mid_in = hi_init >> 1;
         end
      end else if (cmd.advance) begin
         count_in = count_ff + 1'b1;
         if (below) begin
            lo_in  = mid_ff;
            mid_in = sum_up[bsr_pkg::DATA_W:1];
         end else begin
            hi_in  = mid_ff;
            mid_in = sum_dn[bsr_pkg::DATA_W:1];
         end
      end
      if (cmd.settle) begin
         conv_in = in_band;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= bsr_pkg::TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      count_ff  <= count_in;
      conv_ff   <= conv_in;
      target_ff <= target_in;
      lower_ff  <= lower_in;
      upper_ff  <= upper_in;
      if (cmd.square) begin
         prod_ff <= mid_ff * mid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         root_ff     <= mid_ff;
         iter_ff     <= count_wide[bsr_pkg::ITER_W-1:0];
         conv_out_ff <= conv_ff;
      end
   end

   assign stat.special  = is_zero || is_one;
   assign stat.in_band  = in_band;
   assign stat.at_cap   = (count_ff == bsr_pkg::CNT_W'(bsr_pkg::MAX_ITERATIONS));
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_root       = root_ff;
   assign rsp_iterations = iter_ff;
   assign rsp_converged  = conv_out_ff;

endmodule

// ===== rtl/core/bisection_square_root.sv =====
// ----------------------------------------------------------------------------
// bisection_square_root
// Searches each operand by N halvings (N up to 48); an operand of zero or
// exactly one skips the search. Each halving is a multiply step then a
// compare/update step through a single 32x32 squarer. One operand at a time:
// the result is loaded once the output is free, and the next operand is
// accepted once the result is loaded.
// Synchronous reset idles the sequencer, empties the output and sets tolerance.
// ----------------------------------------------------------------------------
module bisection_square_root (
   input  logic                       clock,
   input  logic                       reset,
   bsr_req_if.sink                    req_bus,
   bsr_rsp_if.source                  rsp_bus,
   input  logic                       csr_wr_en,
   input  logic [bsr_pkg::DATA_W-1:0] csr_wr_data
);

   bsr_pkg::bsr_cmd_type  cmd;
   bsr_pkg::bsr_stat_type stat;

   bsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bsr_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_value      (req_bus.value),
      .rsp_ready      (rsp_bus.ready),
      .rsp_valid      (rsp_bus.valid),
      .rsp_root       (rsp_bus.root),
      .rsp_iterations (rsp_bus.iterations),
      .rsp_converged  (rsp_bus.converged)
   );

endmodule

// ===== rtl/core/bsr_checker.sv =====
// ----------------------------------------------------------------------------
// bsr_checker
// Port-level checks for the bisection square root block.
// ----------------------------------------------------------------------------
module bsr_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [bsr_pkg::DATA_W-1:0] rsp_root,
   input logic [bsr_pkg::ITER_W-1:0] rsp_iterations,
   input logic                       rsp_converged
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_root) &&
                                  $stable(rsp_iterations) && $stable(rsp_converged))
      else $error("result changed while stalled");

   // one operand at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("operand accepted while busy");

   // a search that misses the tolerance always ran to the cap
   a_cap_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_converged |->
         rsp_iterations == bsr_pkg::ITER_W'(bsr_pkg::MAX_ITERATIONS))
      else $error("unconverged result below iteration cap");

   // iteration count never exceeds the cap
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 7'(rsp_iterations) <= 7'(bsr_pkg::MAX_ITERATIONS))
      else $error("iteration count out of range");

endmodule

bind bisection_square_root bsr_checker u_bsr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_root       (rsp_bus.root),
   .rsp_iterations (rsp_bus.iterations),
   .rsp_converged  (rsp_bus.converged)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bisection_square_root. Operands are driven on the
// request channel. Each accepted transaction is predicted with a bit-exact
// bisection model at the tolerance in force. Results are matched in order,
// field by field. Directed special operands and tolerance extremes come
// first. Then output stalls, then randomized traffic under three idle profiles.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct {
      logic [bsr_pkg::DATA_W-1:0] root;
      logic [bsr_pkg::ITER_W-1:0] iterations;
      logic                       converged;
   } sqrt_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [bsr_pkg::DATA_W-1:0] csr_wr_data;

   bsr_req_if req_bus ();
   bsr_rsp_if rsp_bus ();

   bisection_square_root i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   sqrt_result_type            pending_roots[$];
   logic [bsr_pkg::DATA_W-1:0] tolerance_q = bsr_pkg::TOL_RESET;
   int                         error_count = 0;
   int                         send_idle_pct = 0;
   int                         rsp_idle_pct = 0;
   int                         hold_left = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #18_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Exact bisection: square kept at 2*FRAC_BITS fraction bits.
   function automatic sqrt_result_type predict_root(
         input logic [bsr_pkg::DATA_W-1:0] v,
         input logic [bsr_pkg::DATA_W-1:0] tol);
      logic [63:0]     target, band, lo, hi, mid, sq, diff;
      int unsigned     count;
      bit              met;
      sqrt_result_type r;
      target = {32'b0, v} << bsr_pkg::FRAC_BITS;
      band   = {32'b0, tol} << bsr_pkg::FRAC_BITS;
      count  = 0;
      met    = 1'b1;
      if (v == '0) begin
         mid = '0;
      end else if (v == bsr_pkg::ONE_FIXED) begin
         mid = {32'b0, bsr_pkg::ONE_FIXED};
      end else begin
         lo  = '0;
         hi  = (v > bsr_pkg::ONE_FIXED) ? {32'b0, v} : {32'b0, bsr_pkg::ONE_FIXED};
         mid = (lo + hi) >> 1;
         forever begin
            sq   = mid * mid;
            diff = (sq >= target) ? sq - target : target - sq;
            met  = (diff <= band);
            if (met || count == bsr_pkg::MAX_ITERATIONS) break;
            if (sq < target) lo = mid;
            else hi = mid;
            mid = (lo + hi) >> 1;
            count++;
         end
      end
      r.root       = mid[bsr_pkg::DATA_W-1:0];
      r.iterations = count[bsr_pkg::ITER_W-1:0];
      r.converged  = met;
      return r;
   endfunction

   // Both channels watched in one process so push/pop order is fixed.
   always @(posedge clock) begin
      sqrt_result_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_roots.size() == 0) begin
               $error("result transaction with none pending: root %h", rsp_bus.root);
               error_count++;
            end else begin
               want = pending_roots.pop_front();
               if (rsp_bus.root !== want.root) begin
                  $error("root: expected %h, got %h", want.root, rsp_bus.root);
                  error_count++;
               end
               if (rsp_bus.iterations !== want.iterations) begin
                  $error("iterations: expected %0d, got %0d",
                         want.iterations, rsp_bus.iterations);
                  error_count++;
               end
               if (rsp_bus.converged !== want.converged) begin
                  $error("converged: expected %b, got %b",
                         want.converged, rsp_bus.converged);
                  error_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            pending_roots.push_back(predict_root(req_bus.value, tolerance_q));
      end
   end

   // Result-side ready; a long hold-off overrides the random stalls.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic send_value(input logic [bsr_pkg::DATA_W-1:0] v);
      int gap;
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         gap = ($urandom_range(9) == 0) ? $urandom_range(10, 110) : $urandom_range(1, 4);
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_roots.size() != 0) @(negedge clock);
   endtask

   task automatic set_tolerance(input logic [bsr_pkg::DATA_W-1:0] t);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= t;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      tolerance_q = t;
   endtask

   function automatic logic [bsr_pkg::DATA_W-1:0] rand_operand();
      logic [15:0] n;
      case ($urandom_range(5))
         0, 1: return $urandom;
         2: return $urandom >> $urandom_range(31);
         3: return $urandom_range(0, 32'hFFFF);        // below 1.0
         4: begin
            n = $urandom;
            return n * n;                             // exact square of n/256
         end
         default: begin
            case ($urandom_range(4))
               0: return '0;
               1: return bsr_pkg::ONE_FIXED;
               2: return bsr_pkg::ONE_FIXED - 1;
               3: return bsr_pkg::ONE_FIXED + 1;
               default: return '1;
            endcase
         end
      endcase
   endfunction

   function automatic logic [bsr_pkg::DATA_W-1:0] rand_tolerance();
      case ($urandom_range(6))
         0: return '0;
         1: return 32'd1;
         2: return bsr_pkg::TOL_RESET;
         3: return '1;
         4: return $urandom_range(0, 32'hFFFF);
         5: return $urandom >> $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_corner_operands();
      logic [bsr_pkg::DATA_W-1:0] corners[7];
      corners = '{32'h0, bsr_pkg::ONE_FIXED, 32'hFFFF_FFFF, 32'h1, 32'h0000_FFFF,
                  32'h0004_0000, 32'h8000_0000};
      foreach (corners[i]) send_value(corners[i]);
   endtask

   // Reset tolerance in force; zero and one take the early exit.
   task automatic test_special_operands();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      send_corner_operands();
      send_value(bsr_pkg::ONE_FIXED + 1);
      send_value(32'h0002_0000);
      wait_drained();
   endtask

   task automatic test_tolerance_extremes();
      set_tolerance('0);          // cap is hit on most operands
      send_corner_operands();
      set_tolerance('1);
      send_corner_operands();
      set_tolerance(32'd1);
      send_value(32'hFFFF_0000);
      send_value(32'h0000_0002);
      wait_drained();
   endtask

   task automatic test_output_stall();
      set_tolerance(bsr_pkg::TOL_RESET);
      send_idle_pct = 0;
      rsp_idle_pct  = 10;
      @(negedge clock);
      hold_left = 400;
      repeat (12) send_value(rand_operand());
      wait_drained();
      repeat (8) send_value(rand_operand());
      wait_drained();
   endtask

   task automatic test_random_operands(input int count, input int snd_pct, input int rsp_pct);
      send_idle_pct = snd_pct;
      rsp_idle_pct  = rsp_pct;
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) set_tolerance(rand_tolerance());
         send_value(rand_operand());
      end
      wait_drained();
   endtask

   initial begin
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_special_operands();
      test_tolerance_extremes();
      test_output_stall();
      test_random_operands(317, 22, 83);
      test_random_operands(317, 83, 22);
      test_random_operands(316, 0, 0);

      wait_drained();
      repeat (110) @(negedge clock);
      if (pending_roots.size() != 0) begin
         $error("%0d expected results never arrived", pending_roots.size());
         error_count++;
      end
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
